### rtl/core/assert_macros.svh
// Assertion helpers used by the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### rtl/core/jdc_pkg.sv
`timescale 1ns / 1ps
package jdc_pkg;

  localparam int FRAC_BITS = 16;

  localparam int DN_W   = 39;
  localparam int HOUR_W = 21;
  localparam int YEAR_W = 15;
  localparam int IN_W   = 88;
  localparam int OUT_W  = 88;

  localparam logic OP_TO_DAY  = 1'b0;
  localparam logic OP_TO_DATE = 1'b1;

  // integer day part of the day number, one extra bit for the half-day offset
  localparam int Z_W = DN_W - FRAC_BITS + 1;

  localparam logic [31:0] GREG_START_JD = 32'd2299161;
  localparam logic [31:0] ALPHA_OFS     = 32'd7468865;
  localparam logic [31:0] DAYS_400Y     = 32'd146097;
  localparam logic [31:0] B_OFS         = 32'd1524;
  localparam logic [31:0] C_OFS         = 32'd28038;
  localparam logic [31:0] QUARTER_YEARS = 32'd7305;
  localparam logic [31:0] DAYS_4Y       = 32'd1461;
  localparam logic [31:0] MONTH_NUM     = 32'd306001;
  localparam logic [31:0] MONTH_DEN     = 32'd10000;
  localparam logic [31:0] JD_OFS        = 32'd1720994;

  // alpha = (4z - 7468865) / 146097
  localparam int N1_W = Z_W + 2;
  localparam logic [63:0] R1 = (64'd1 << N1_W) / 64'd146097;
  localparam int R1_W = $clog2(R1 + 1);

  // (z + 1) / 7 for the weekday
  localparam logic [63:0] R7 = (64'd1 << Z_W) / 64'd7;
  localparam int R7_W = $clog2(R7 + 1);

  // c = (20b - 2442) / 7305
  localparam int N2_W = Z_W + 5;
  localparam logic [63:0] R2 = (64'd1 << N2_W) / 64'd7305;
  localparam int R2_W = $clog2(R2 + 1);
  localparam int C_W  = R2_W;

  // value / 100 on 15-bit magnitudes
  localparam logic [63:0] R100 = (64'd1 << YEAR_W) / 64'd100;
  localparam int R100_W = $clog2(R100 + 1);

  // hour / 24 as (hour + 12) >> 3, then / 3
  localparam int HX_W = HOUR_W - 2;
  localparam logic [63:0] RH = (64'd1 << HX_W) / 64'd3;
  localparam int RH_W = $clog2(RH + 1);

  // e = 10000 * bd / 306001, bd below 1024
  localparam int BD_W = 10;
  localparam int KE   = 24;
  localparam logic [63:0] RE = ((64'd1 << KE) / 64'd306001) * 64'd10000;
  localparam int RE_W = $clog2(RE + 1);

  localparam int WH_W = 26;
  localparam int Q_W  = WH_W + FRAC_BITS + 2;

  // floor(30.6001 * k)
  function automatic logic [8:0] month_offset(input logic [4:0] k);
    logic [8:0] v;
    case (k)
      5'd0:    v = 9'd0;
      5'd1:    v = 9'd30;
      5'd2:    v = 9'd61;
      5'd3:    v = 9'd91;
      5'd4:    v = 9'd122;
      5'd5:    v = 9'd153;
      5'd6:    v = 9'd183;
      5'd7:    v = 9'd214;
      5'd8:    v = 9'd244;
      5'd9:    v = 9'd275;
      5'd10:   v = 9'd306;
      5'd11:   v = 9'd336;
      5'd12:   v = 9'd367;
      5'd13:   v = 9'd397;
      5'd14:   v = 9'd428;
      5'd15:   v = 9'd459;
      5'd16:   v = 9'd489;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/julian_day_converter.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Julian day converter. in_tuser selects the conversion: 0 turns a calendar
// date and an hour into a Julian day number, 1 turns a day number into year,
// month, day, hour, weekday (0 = Sunday) and a Gregorian leap-year flag, with
// the calendar reform at 1582-10-15. Day numbers and hours carry 16 fraction
// bits. A new transaction is accepted every cycle while the output is not
// stalled; each one passes in order through the registered stages, a chain of
// constant divisions done as reciprocal multiplies with one correction stage
// each. The whole pipeline holds while the output register waits on out_tready.
module julian_day_converter (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // year[14:0], month[18:15], day_of_month[23:19], hour_q16[44:24],
  // day_number_q16[83:45], zero pad[87:84]
  input  logic [jdc_pkg::IN_W-1:0]  in_tdata,
  // operation[0]
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_day_number_q16[38:0], out_year[53:39], out_month[57:54],
  // out_day[62:58], out_hour_q16[83:63], weekday[86:84], leap_year[87]
  output logic [jdc_pkg::OUT_W-1:0] out_tdata
);
  import jdc_pkg::*;

  logic en;
  logic [11:0] v_r;

  assign en         = !v_r[11] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = v_r[11];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[10:0], in_tvalid};
    end
  end

  // ---------------- stage 1 ----------------
  logic signed [YEAR_W-1:0] in_year;
  logic [3:0]          in_month;
  logic [4:0]          in_day;
  logic [HOUR_W-1:0]   in_hour;
  logic [DN_W-1:0]     in_dn;
  logic [DN_W:0]       jj;
  logic [Z_W-1:0]      z;
  logic [FRAC_BITS+4:0] hp;
  logic signed [15:0]  ye;
  logic [4:0]          mk;
  logic [21:0]         hs;

  assign in_year  = signed'(in_tdata[14:0]);
  assign in_month = in_tdata[18:15];
  assign in_day   = in_tdata[23:19];
  assign in_hour  = in_tdata[44:24];
  assign in_dn    = in_tdata[83:45];
  assign jj = {1'b0, in_dn} + ((DN_W+1)'(1) << (FRAC_BITS - 1));
  assign z  = jj[DN_W:FRAC_BITS];
  assign hp = {5'd0, jj[FRAC_BITS-1:0]} * (FRAC_BITS+5)'(24);
  assign ye = {in_year[YEAR_W-1], in_year};
  assign mk = (in_month > 4'd2) ? ({1'b0, in_month} + 5'd1) : ({1'b0, in_month} + 5'd13);
  assign hs = 22'(in_hour) + 22'd12;

  logic                 op1_r, greg1_1_r, greg0_1_r;
  logic [Z_W-1:0]       z1_r, wv1_r;
  logic [N1_W-1:0]      n1_1_r;
  logic [HOUR_W-1:0]    hour1_r;
  logic signed [15:0]   y1_r;
  logic [8:0]           t2_1_r;
  logic [4:0]           day1_r;
  logic [HX_W-1:0]      hx1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r     <= in_tuser;
      z1_r      <= z;
      wv1_r     <= z + Z_W'(1);
      n1_1_r    <= {z, 2'b00} - N1_W'(ALPHA_OFS);
      greg1_1_r <= z >= Z_W'(GREG_START_JD);
      hour1_r   <= HOUR_W'(hp);
      y1_r      <= (in_month > 4'd2) ? ye : ye - 16'sd1;
      t2_1_r    <= month_offset(mk);
      day1_r    <= in_day;
      greg0_1_r <= (in_year > 15'sd1582) ||
                   (in_year == 15'sd1582 &&
                    (in_month > 4'd10 || (in_month == 4'd10 && in_day >= 5'd15)));
      hx1_r     <= hs[21:3];
    end
  end

  // ---------------- stage 2 ----------------
  logic [N1_W+R1_W-1:0]     p1;
  logic [Z_W+R7_W-1:0]      p7;
  logic signed [27:0]       pt1;
  logic [YEAR_W+R100_W-1:0] pa;
  logic [HX_W+RH_W-1:0]     ph;

  assign p1  = (N1_W+R1_W)'(n1_1_r) * (N1_W+R1_W)'(R1);
  assign p7  = (Z_W+R7_W)'(wv1_r) * (Z_W+R7_W)'(R7);
  assign pt1 = 28'(y1_r) * 28'sd1461;
  assign pa  = (YEAR_W+R100_W)'(y1_r[YEAR_W-1:0]) * (YEAR_W+R100_W)'(R100);
  assign ph  = (HX_W+RH_W)'(hx1_r) * (HX_W+RH_W)'(RH);

  logic                 op2_r, greg1_2_r, greg0_2_r;
  logic [Z_W-1:0]       z2_r, wv2_r;
  logic [N1_W-1:0]      n1_2_r;
  logic [R1_W-1:0]      alq2_r;
  logic [R7_W-1:0]      wq2_r;
  logic [HOUR_W-1:0]    hour2_r;
  logic signed [WH_W-1:0] t1_2_r;
  logic [8:0]           t2_2_r;
  logic [4:0]           day2_r;
  logic [YEAR_W-1:0]    ya2_r;
  logic [R100_W-1:0]    aq2_r;
  logic [HX_W-1:0]      hx2_r;
  logic [RH_W-1:0]      hq2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      op2_r     <= op1_r;
      greg1_2_r <= greg1_1_r;
      greg0_2_r <= greg0_1_r;
      z2_r      <= z1_r;
      wv2_r     <= wv1_r;
      n1_2_r    <= n1_1_r;
      alq2_r    <= p1[N1_W+R1_W-1:N1_W];
      wq2_r     <= p7[Z_W+R7_W-1:Z_W];
      hour2_r   <= hour1_r;
      t1_2_r    <= WH_W'(pt1 >>> 2);
      t2_2_r    <= t2_1_r;
      day2_r    <= day1_r;
      ya2_r     <= y1_r[YEAR_W-1:0];
      aq2_r     <= pa[YEAR_W+R100_W-1:YEAR_W];
      hx2_r     <= hx1_r;
      hq2_r     <= ph[HX_W+RH_W-1:HX_W];
    end
  end

  // ---------------- stage 3 ----------------
  logic [N1_W-1:0]   r1;
  logic [Z_W-1:0]    r7, r7c;
  logic [YEAR_W-1:0] ra;
  logic [HX_W-1:0]   rh;

  assign r1  = n1_2_r - N1_W'(alq2_r * DAYS_400Y);
  assign r7  = wv2_r - Z_W'(wq2_r * Z_W'(7));
  assign r7c = (r7 >= Z_W'(7)) ? r7 - Z_W'(7) : r7;
  assign ra  = ya2_r - YEAR_W'(aq2_r * YEAR_W'(100));
  assign rh  = hx2_r - HX_W'(hq2_r * HX_W'(3));

  logic                 op3_r, greg1_3_r, greg0_3_r;
  logic [Z_W-1:0]       z3_r;
  logic [R1_W-1:0]      al3_r;
  logic [2:0]           wd3_r;
  logic [HOUR_W-1:0]    hour3_r;
  logic signed [WH_W-1:0] whole3_r;
  logic [R100_W-1:0]    a3_r;
  logic [RH_W-1:0]      hq3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      op3_r     <= op2_r;
      greg1_3_r <= greg1_2_r;
      greg0_3_r <= greg0_2_r;
      z3_r      <= z2_r;
      al3_r     <= alq2_r + R1_W'(r1 >= N1_W'(DAYS_400Y));
      wd3_r     <= r7c[2:0];
      hour3_r   <= hour2_r;
      whole3_r  <= t1_2_r + WH_W'(t2_2_r) + WH_W'(day2_r) + WH_W'(JD_OFS);
      a3_r      <= aq2_r + R100_W'(ra >= YEAR_W'(100));
      hq3_r     <= hq2_r + RH_W'(rh >= HX_W'(3));
    end
  end

  // ---------------- stage 4 ----------------
  logic [Z_W-1:0]       a_jd;
  logic [WH_W-1:0]      corr;

  assign a_jd = greg1_3_r ?
                (z3_r + Z_W'(1) + Z_W'(al3_r) - Z_W'(al3_r >> 2)) : z3_r;
  assign corr = WH_W'(2) - WH_W'(a3_r) + WH_W'(a3_r >> 2);

  logic                 op4_r;
  logic [Z_W-1:0]       b4_r;
  logic [N2_W-1:0]      n2_4_r;
  logic [2:0]           wd4_r;
  logic [HOUR_W-1:0]    hour4_r;
  logic signed [WH_W-1:0] whole4_r;
  logic [RH_W-1:0]      hq4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      op4_r    <= op3_r;
      b4_r     <= a_jd + Z_W'(B_OFS);
      n2_4_r   <= N2_W'(a_jd) * N2_W'(20) + N2_W'(C_OFS);
      wd4_r    <= wd3_r;
      hour4_r  <= hour3_r;
      whole4_r <= whole3_r + (greg0_3_r ? signed'(corr) : WH_W'(0));
      hq4_r    <= hq3_r;
    end
  end

  // ---------------- stage 5 ----------------
  logic [N2_W+R2_W-1:0] pc;

  assign pc = (N2_W+R2_W)'(n2_4_r) * (N2_W+R2_W)'(R2);

  logic                 op5_r;
  logic [Z_W-1:0]       b5_r;
  logic [N2_W-1:0]      n2_5_r;
  logic [R2_W-1:0]      cq5_r;
  logic [2:0]           wd5_r;
  logic [HOUR_W-1:0]    hour5_r;
  logic signed [Q_W-1:0] q5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      op5_r   <= op4_r;
      b5_r    <= b4_r;
      n2_5_r  <= n2_4_r;
      cq5_r   <= pc[N2_W+R2_W-1:N2_W];
      wd5_r   <= wd4_r;
      hour5_r <= hour4_r;
      q5_r    <= (Q_W'(whole4_r) <<< FRAC_BITS) + (Q_W'(1) << (FRAC_BITS - 1)) +
                 Q_W'(hq4_r);
    end
  end

  // ---------------- stage 6 ----------------
  logic [N2_W-1:0] rc;

  assign rc = n2_5_r - N2_W'(cq5_r * QUARTER_YEARS);

  logic                 op6_r;
  logic [Z_W-1:0]       b6_r;
  logic [C_W-1:0]       c6_r;
  logic [2:0]           wd6_r;
  logic [HOUR_W-1:0]    hour6_r;
  logic [DN_W-1:0]      dn6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      op6_r   <= op5_r;
      b6_r    <= b5_r;
      c6_r    <= cq5_r + C_W'(rc >= N2_W'(QUARTER_YEARS));
      wd6_r   <= wd5_r;
      hour6_r <= hour5_r;
      // clamp to the day number range
      if (q5_r < 0) begin
        dn6_r <= '0;
      end else if (q5_r > signed'({{(Q_W-DN_W){1'b0}}, {DN_W{1'b1}}})) begin
        dn6_r <= '1;
      end else begin
        dn6_r <= q5_r[DN_W-1:0];
      end
    end
  end

  // ---------------- stage 7 ----------------
  logic [C_W+10:0] pd;

  assign pd = (C_W+11)'(c6_r) * (C_W+11)'(DAYS_4Y);

  logic                 op7_r;
  logic [C_W-1:0]       c7_r;
  logic [BD_W-1:0]      bd7_r;
  logic [2:0]           wd7_r;
  logic [HOUR_W-1:0]    hour7_r;
  logic [DN_W-1:0]      dn7_r;

  always_ff @(posedge clk) begin
    if (en) begin
      op7_r   <= op6_r;
      c7_r    <= c6_r;
      bd7_r   <= BD_W'(b6_r - Z_W'(pd >> 2));
      wd7_r   <= wd6_r;
      hour7_r <= hour6_r;
      dn7_r   <= dn6_r;
    end
  end

  // ---------------- stage 8 ----------------
  logic [BD_W+RE_W-1:0] pe;

  assign pe = (BD_W+RE_W)'(bd7_r) * (BD_W+RE_W)'(RE);

  logic                 op8_r;
  logic [C_W-1:0]       c8_r;
  logic [BD_W-1:0]      bd8_r;
  logic [BD_W+RE_W-KE-1:0] eq8_r;
  logic [2:0]           wd8_r;
  logic [HOUR_W-1:0]    hour8_r;
  logic [DN_W-1:0]      dn8_r;

  always_ff @(posedge clk) begin
    if (en) begin
      op8_r   <= op7_r;
      c8_r    <= c7_r;
      bd8_r   <= bd7_r;
      eq8_r   <= pe[BD_W+RE_W-1:KE];
      wd8_r   <= wd7_r;
      hour8_r <= hour7_r;
      dn8_r   <= dn7_r;
    end
  end

  // ---------------- stage 9 ----------------
  logic [KE-1:0] n3, re;

  assign n3 = KE'(bd8_r) * KE'(MONTH_DEN);
  assign re = n3 - KE'(eq8_r * MONTH_NUM);

  logic                 op9_r;
  logic [C_W-1:0]       c9_r;
  logic [BD_W-1:0]      bd9_r;
  logic [4:0]           e9_r;
  logic [2:0]           wd9_r;
  logic [HOUR_W-1:0]    hour9_r;
  logic [DN_W-1:0]      dn9_r;

  always_ff @(posedge clk) begin
    if (en) begin
      op9_r   <= op8_r;
      c9_r    <= c8_r;
      bd9_r   <= bd8_r;
      e9_r    <= 5'(eq8_r + (BD_W+RE_W-KE)'(re >= KE'(MONTH_NUM)));
      wd9_r   <= wd8_r;
      hour9_r <= hour8_r;
      dn9_r   <= dn8_r;
    end
  end

  // ---------------- stage 10 ----------------
  logic                  late_year;
  logic signed [C_W+1:0] yr;

  // month > 2 picks the earlier year offset
  assign late_year = (e9_r < 5'd14) ? (e9_r > 5'd3) : (e9_r > 5'd15);
  assign yr = signed'((C_W+2)'(c9_r)) - (late_year ? (C_W+2)'(4716) : (C_W+2)'(4715));

  logic                 op10_r;
  logic [4:0]           day10_r;
  logic [3:0]           mon10_r;
  logic signed [YEAR_W-1:0] year10_r;
  logic [2:0]           wd10_r;
  logic [HOUR_W-1:0]    hour10_r;
  logic [DN_W-1:0]      dn10_r;

  always_ff @(posedge clk) begin
    if (en) begin
      op10_r   <= op9_r;
      day10_r  <= 5'(bd9_r - BD_W'(month_offset(e9_r)));
      mon10_r  <= (e9_r < 5'd14) ? 4'(e9_r - 5'd1) : 4'(e9_r - 5'd13);
      wd10_r   <= wd9_r;
      hour10_r <= hour9_r;
      dn10_r   <= dn9_r;
      if (yr > signed'((C_W+2)'(16383))) begin
        year10_r <= 15'sd16383;
      end else if (yr < -signed'((C_W+2)'(16384))) begin
        year10_r <= -15'sd16384;
      end else begin
        year10_r <= YEAR_W'(yr);
      end
    end
  end

  // ---------------- stage 11 ----------------
  logic [YEAR_W:0]          yabs;
  logic [YEAR_W+R100_W-1:0] py;

  assign yabs = year10_r[YEAR_W-1] ? -(YEAR_W+1)'(year10_r) : (YEAR_W+1)'(year10_r);
  assign py   = (YEAR_W+R100_W)'(yabs[YEAR_W-1:0]) * (YEAR_W+R100_W)'(R100);

  logic                 op11_r;
  logic [4:0]           day11_r;
  logic [3:0]           mon11_r;
  logic signed [YEAR_W-1:0] year11_r;
  logic [YEAR_W-1:0]    yabs11_r;
  logic [R100_W-1:0]    yq11_r;
  logic [2:0]           wd11_r;
  logic [HOUR_W-1:0]    hour11_r;
  logic [DN_W-1:0]      dn11_r;

  always_ff @(posedge clk) begin
    if (en) begin
      op11_r   <= op10_r;
      day11_r  <= day10_r;
      mon11_r  <= mon10_r;
      year11_r <= year10_r;
      yabs11_r <= yabs[YEAR_W-1:0];
      yq11_r   <= py[YEAR_W+R100_W-1:YEAR_W];
      wd11_r   <= wd10_r;
      hour11_r <= hour10_r;
      dn11_r   <= dn10_r;
    end
  end

  // ---------------- output register ----------------
  logic [YEAR_W-1:0] ry, ryc;
  logic [R100_W-1:0] yqc;
  logic              leap;

  assign ry   = yabs11_r - YEAR_W'(yq11_r * YEAR_W'(100));
  assign ryc  = (ry >= YEAR_W'(100)) ? ry - YEAR_W'(100) : ry;
  assign yqc  = yq11_r + R100_W'(ry >= YEAR_W'(100));
  assign leap = (year11_r[1:0] == 2'b00) && ((ryc != '0) || (yqc[1:0] == 2'b00));

  logic [OUT_W-1:0] out_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (op11_r == OP_TO_DATE) begin
        out_r <= {leap, wd11_r, hour11_r, day11_r, mon11_r, year11_r, {DN_W{1'b0}}};
      end else begin
        out_r <= {{(OUT_W-DN_W){1'b0}}, dn11_r};
      end
    end
  end

  assign out_tdata = out_r;

  `ASSERT_IMPLY(a_weekday_range, clk, rst_n, out_tvalid, out_tdata[86:84] < 3'd7)
  `ASSERT_IMPLY(a_exclusive_fields, clk, rst_n, out_tvalid && out_tdata[38:0] != '0,
                out_tdata[87:39] == '0)
  `ASSERT_NEXT(a_stall_holds, clk, rst_n, !en, $stable(v_r))
  `ASSERT_NEXT(a_accept_enters, clk, rst_n, in_tvalid && in_tready, v_r[0])

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import jdc_pkg::*;

  typedef struct packed {
    logic        leap_year;
    logic [2:0]  weekday;
    logic [20:0] hour_q16;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [14:0] year;
    logic [38:0] day_number_q16;
  } conv_result_t;

  typedef struct {
    logic        op;
    logic [14:0] year;
    logic [3:0]  month;
    logic [4:0]  dom;
    logic [20:0] hour;
    logic [38:0] dn;
    logic        has_exp;
    logic [38:0] exp_dn;
    logic [14:0] exp_year;
    logic [3:0]  exp_month;
    logic [4:0]  exp_day;
  } dir_row_t;

  localparam longint MAX_DN = (64'd1 << 39) - 1;
  localparam int LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  conv_result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  bit calm = 1'b0;

  julian_day_converter dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic conv_result_t convert(logic op, logic [14:0] yr, logic [3:0] mo,
                                           logic [4:0] dm, logic [20:0] hr,
                                           logic [38:0] dn);
    conv_result_t r;
    longint year, month, day, y, m, whole, q, a, z, fr, jj, al, b, c, d, e;
    bit greg;
    r = '0;
    if (op == OP_TO_DAY) begin
      year = longint'(signed'(yr));
      month = mo;
      day = dm;
      if (month > 2) begin
        y = year; m = month;
      end else begin
        y = year - 1; m = month + 12;
      end
      whole = floor_div(1461 * y, 4) + floor_div(306001 * (m + 1), 10000) + day + 1720994;
      greg = (year > 1582) || (year == 1582 && (month > 10 || (month == 10 && day >= 15)));
      if (greg) begin
        a = y / 100;
        whole += 2 - a + a / 4;
      end
      q = whole * 65536 + 32768 + (longint'(hr) + 12) / 24;
      if (q < 0) q = 0;
      if (q > MAX_DN) q = MAX_DN;
      r.day_number_q16 = q[38:0];
    end else begin
      jj = longint'(dn) + 32768;
      z = jj >>> 16;
      fr = jj & 16'hFFFF;
      if (z < 2299161) a = z;
      else begin
        al = floor_div(4 * z - 7468865, 146097);
        a = z + 1 + al - floor_div(al, 4);
      end
      b = a + 1524;
      c = floor_div(20 * b - 2442, 7305);
      d = floor_div(1461 * c, 4);
      e = floor_div(10000 * (b - d), 306001);
      day = b - d - floor_div(306001 * e, 10000);
      month = (e < 14) ? e - 1 : e - 13;
      year = (month > 2) ? c - 4716 : c - 4715;
      if (year > 16383) year = 16383;
      if (year < -16384) year = -16384;
      r.year = year[14:0];
      r.month = month[3:0];
      r.day = day[4:0];
      r.hour_q16 = 21'(fr * 24);
      r.weekday = 3'((z + 1) % 7);
      r.leap_year = ((year % 4) == 0) && (((year % 100) != 0) || ((year % 400) == 0));
    end
    return r;
  endfunction

  // Drive one transaction and hold it until accepted.
  task automatic send_item(logic op, logic [14:0] yr, logic [3:0] mo, logic [4:0] dm,
                           logic [20:0] hr, logic [38:0] dn);
    while (!calm && $urandom_range(99) < 8) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {4'b0, dn, hr, dm, mo, yr};
    pending_results.push_back(convert(op, yr, mo, dm, hr, dn));
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("julian_day_converter regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 8);
  end

  // Compare every accepted result with the oldest pending one.
  always @(posedge clk) begin
    conv_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_results.size() == 0) begin
        $error("unexpected result %h", out_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.day_number_q16 !== want.day_number_q16) begin
          $error("out_day_number_q16 exp %h got %h", want.day_number_q16, got.day_number_q16);
          errors++;
        end
        if (got.year !== want.year) begin
          $error("out_year exp %h got %h", want.year, got.year); errors++;
        end
        if (got.month !== want.month) begin
          $error("out_month exp %h got %h", want.month, got.month); errors++;
        end
        if (got.day !== want.day) begin
          $error("out_day exp %h got %h", want.day, got.day); errors++;
        end
        if (got.hour_q16 !== want.hour_q16) begin
          $error("out_hour_q16 exp %h got %h", want.hour_q16, got.hour_q16); errors++;
        end
        if (got.weekday !== want.weekday) begin
          $error("weekday exp %h got %h", want.weekday, got.weekday); errors++;
        end
        if (got.leap_year !== want.leap_year) begin
          $error("leap_year exp %h got %h", want.leap_year, got.leap_year); errors++;
        end
      end
    end
  end

  dir_row_t dir_rows[] = '{
    // J2000.0 noon
    '{OP_TO_DAY, 15'd2000, 4'd1, 5'd1, 21'd786432, 39'd0, 1'b1,
      39'd2451545 << 16, 15'd0, 4'd0, 5'd0},
    '{OP_TO_DATE, 15'd0, 4'd0, 5'd0, 21'd0, 39'd2451545 << 16, 1'b1,
      39'd0, 15'd2000, 4'd1, 5'd1},
    // last Julian day and first Gregorian day
    '{OP_TO_DAY, 15'd1582, 4'd10, 5'd4, 21'd0, 39'd0, 1'b0, 39'd0, 15'd0, 4'd0, 5'd0},
    '{OP_TO_DAY, 15'd1582, 4'd10, 5'd15, 21'd0, 39'd0, 1'b0, 39'd0, 15'd0, 4'd0, 5'd0},
    '{OP_TO_DAY, 15'd1582, 4'd10, 5'd14, 21'd0, 39'd0, 1'b0, 39'd0, 15'd0, 4'd0, 5'd0},
    '{OP_TO_DAY, 15'd1582, 4'd11, 5'd1, 21'd0, 39'd0, 1'b0, 39'd0, 15'd0, 4'd0, 5'd0},
    '{OP_TO_DATE, 15'd0, 4'd0, 5'd0, 21'd0, 39'd2299160 << 16, 1'b0, 39'd0, 15'd0, 4'd0, 5'd0},
    '{OP_TO_DATE, 15'd0, 4'd0, 5'd0, 21'd0, 39'd2299161 << 16, 1'b0, 39'd0, 15'd0, 4'd0, 5'd0},
    // epoch -4712-01-01 noon is day 0
    '{OP_TO_DAY, -15'sd4712, 4'd1, 5'd1, 21'd786432, 39'd0, 1'b1, 39'd0, 15'd0, 4'd0, 5'd0},
    '{OP_TO_DAY, 15'h4000, 4'd1, 5'd1, 21'd0, 39'd0, 1'b1, 39'd0, 15'd0, 4'd0, 5'd0},
    '{OP_TO_DAY, 15'h3FFF, 4'd15, 5'd31, 21'h1FFFFF, 39'd0, 1'b0, 39'd0, 15'd0, 4'd0, 5'd0},
    '{OP_TO_DAY, 15'd9999, 4'd12, 5'd31, 21'd1572863, 39'd0, 1'b0, 39'd0, 15'd0, 4'd0, 5'd0},
    // months zero and above twelve
    '{OP_TO_DAY, 15'd2024, 4'd0, 5'd0, 21'd12, 39'd0, 1'b0, 39'd0, 15'd0, 4'd0, 5'd0},
    '{OP_TO_DAY, 15'd2024, 4'd13, 5'd10, 21'd36, 39'd0, 1'b0, 39'd0, 15'd0, 4'd0, 5'd0},
    '{OP_TO_DAY, 15'd1900, 4'd2, 5'd29, 21'd11, 39'd0, 1'b0, 39'd0, 15'd0, 4'd0, 5'd0},
    '{OP_TO_DATE, 15'd0, 4'd0, 5'd0, 21'd0, 39'd0, 1'b0, 39'd0, 15'd0, 4'd0, 5'd0},
    '{OP_TO_DATE, 15'h7FFF, 4'hF, 5'h1F, 21'h1FFFFF, 39'h7FFFFFFFFF, 1'b0,
      39'd0, 15'd0, 4'd0, 5'd0},
    '{OP_TO_DATE, 15'd0, 4'd0, 5'd0, 21'd0, 39'h00007FFF, 1'b0, 39'd0, 15'd0, 4'd0, 5'd0},
    '{OP_TO_DATE, 15'd0, 4'd0, 5'd0, 21'd0, (39'd2451604 << 16) + 39'hFFFF, 1'b0,
      39'd0, 15'd0, 4'd0, 5'd0},
    '{OP_TO_DATE, 15'd0, 4'd0, 5'd0, 21'd0, 39'd5373484 << 16, 1'b0, 39'd0, 15'd0, 4'd0, 5'd0}
  };

  initial begin
    conv_result_t r;
    logic [14:0] yr;
    logic [38:0] dn;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].has_exp) begin
        r = convert(dir_rows[i].op, dir_rows[i].year, dir_rows[i].month, dir_rows[i].dom,
                    dir_rows[i].hour, dir_rows[i].dn);
        if (r.day_number_q16 !== dir_rows[i].exp_dn || r.year !== dir_rows[i].exp_year ||
            r.month !== dir_rows[i].exp_month || r.day !== dir_rows[i].exp_day) begin
          $error("table row %0d disagrees with predictor", i);
          errors++;
        end
      end
      send_item(dir_rows[i].op, dir_rows[i].year, dir_rows[i].month, dir_rows[i].dom,
                dir_rows[i].hour, dir_rows[i].dn);
    end
    // sender pause until every result is back
    drain();
    for (int n = 0; n < 900; n++) begin
      calm = (n >= 300 && n < 450);
      if ($urandom_range(9) < 8) yr = 15'($signed($urandom_range(14711)) - 4712);
      else yr = 15'($urandom);
      if ($urandom_range(3) == 0) dn = 39'({$urandom, $urandom} & MAX_DN);
      else dn = 39'($urandom_range(5373484)) * 65536 + 39'($urandom_range(65535));
      send_item(1'($urandom_range(1)), yr,
                ($urandom_range(9) < 8) ? 4'($urandom_range(12, 1)) : 4'($urandom),
                ($urandom_range(9) < 8) ? 5'($urandom_range(31, 1)) : 5'($urandom),
                ($urandom_range(9) < 8) ? 21'($urandom_range(1572863)) : 21'($urandom),
                dn);
      if (n == 600) drain();
    end
    calm = 1'b0;
    drain();
    if (errors == 0) begin
      $display("julian_day_converter regression: pass");
    end else begin
      $display("julian_day_converter regression: fail");
    end
    $finish;
  end
endmodule
